FILE: hdl/stuffed_frame_receiver_crc16_assert.svh
// Assertion macros used by the frame receiver core (sfr_core).
`ifndef STUFFED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

FILE: hdl/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

    // Stream field widths
    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int LEN_W    = 8;
    localparam int TDATA_W  = 24;
    localparam int CFG_IDX_W = 1;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
    localparam logic [BYTE_W-1:0] CH_DLE = 8'h10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT = 1'b1;

    // Configuration reset values (XMODEM)
    localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT_RST = 16'h0000;

    // One result item
    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_restart;
        logic              overflow;
        logic              frame_end;
        logic              frame_ok;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

endpackage

FILE: hdl/sfr_crc_fold.sv
`timescale 1ns / 1ps
module sfr_crc_fold (
    input  logic [sfr_pkg::CRC_W-1:0]  i_crc,
    input  logic [sfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [sfr_pkg::CRC_W-1:0]  i_poly,
    output logic [sfr_pkg::CRC_W-1:0]  o_crc
);
    import sfr_pkg::*;

    // MSB-first byte update: eight shift/xor steps
    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (v_crc[CRC_W-1]) begin
                v_crc = {v_crc[CRC_W-2:0], 1'b0} ^ i_poly;
            end else begin
                v_crc = {v_crc[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

FILE: hdl/sfr_core.sv
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_crc16_assert.svh"
module sfr_core #(
    parameter int BUF_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CRC_W-1:0]    i_cfg_data,
    input  logic                         i_step,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_byte,
    output sfr_pkg::t_result             o_result
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(BUF_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUF_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] LEN_MAX   = CNT_W'(255);

    // Configuration registers
    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] r_init;

    // Frame state
    logic              r_escape, n_escape;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [BYTE_W-1:0] r_hold0,  n_hold0;
    logic [BYTE_W-1:0] r_hold1,  n_hold1;
    logic [CRC_W-1:0]  r_acc,    n_acc;

    logic [CRC_W-1:0]  w_fold;
    logic              w_ovf;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_len;

    sfr_crc_fold u_fold (
        .i_crc  (r_acc),
        .i_byte (r_hold0),
        .i_poly (r_poly),
        .o_crc  (w_fold)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= CRC_POLY_RST;
            r_init <= CRC_INIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_POLY: r_poly <= i_cfg_data;
                CFG_IDX_INIT: r_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Overflow check ahead of byte handling
    assign w_ovf = (r_count >= CNT_LIMIT);
    assign w_cnt = w_ovf ? '0 : r_count;
    assign w_len = w_cnt - CNT_TWO;

    // Byte decode and next state
    always_comb begin
        logic v_take;
        n_escape = r_escape;
        n_count  = w_cnt;
        n_hold0  = r_hold0;
        n_hold1  = r_hold1;
        n_acc    = r_acc;
        o_result = '0;
        o_result.overflow      = w_ovf;
        o_result.frame_restart = w_ovf;
        v_take = 1'b0;

        priority if (r_escape) begin
            n_escape = 1'b0;
            v_take   = 1'b1;
        end else if (i_byte == CH_SOH) begin
            n_count = '0;
            o_result.frame_restart = 1'b1;
        end else if (i_byte == CH_DLE) begin
            n_escape = 1'b1;
        end else if (i_byte == CH_EOT) begin
            o_result.frame_end = 1'b1;
            if (w_cnt >= CNT_TWO) begin
                o_result.frame_ok = ({r_hold1, r_hold0} == r_acc) && (w_cnt > CNT_TWO);
                o_result.payload_length = (w_len > LEN_MAX) ? 8'hFF : LEN_W'(w_len);
            end
        end else begin
            v_take = 1'b1;
        end

        // Data byte into the two-byte hold
        if (v_take) begin
            n_count = w_cnt + CNT_W'(1);
            if (w_cnt == '0) begin
                n_acc   = r_init;
                n_hold0 = i_byte;
            end else if (w_cnt == CNT_W'(1)) begin
                n_hold1 = i_byte;
            end else begin
                o_result.data_valid = 1'b1;
                o_result.data_byte  = r_hold0;
                n_acc   = w_fold;
                n_hold0 = r_hold1;
                n_hold1 = i_byte;
            end
        end
    end

    // State update, one byte per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 1'b0;
            r_count  <= '0;
            r_acc    <= CRC_INIT_RST;
        end else if (i_step) begin
            r_escape <= n_escape;
            r_count  <= n_count;
            r_acc    <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hold0 <= n_hold0;
            r_hold1 <= n_hold1;
        end
    end

    // Checks
    `SFR_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_LIMIT)
    `SFR_ASSERT_IMPL(a_ok_needs_end, i_clk, i_rst_n, o_result.frame_ok, o_result.frame_end)
    `SFR_ASSERT_IMPL(a_ovf_restarts, i_clk, i_rst_n, o_result.overflow, o_result.frame_restart)
    `SFR_ASSERT_IMPL(a_no_data_at_end, i_clk, i_rst_n, o_result.frame_end, !o_result.data_valid)
    `SFR_ASSERT_NEXT(a_soh_clears, i_clk, i_rst_n,
        i_step && !r_escape && (i_byte == CH_SOH), r_count == '0)

endmodule

FILE: hdl/stuffed_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// Byte-stuffed frame receiver with CRC-16 check.
// Input stream: one raw link byte per request on s_axis. SOH restarts a frame,
// DLE escapes the next byte, EOT ends the frame; other bytes are data.
// Output stream: one result per input byte on m_axis. tuser flags a released
// payload byte in tdata[7:0]; tlast marks EOT, with frame_ok and
// payload_length valid on that result. The last two data bytes are kept as the
// received CRC (low byte first) and compared with the running CRC-16.
// Config port: i_cfg_we with i_cfg_index 0 writes the polynomial, 1 writes the
// initial value (used at the next frame start). Write only while idle.
// Path: the input register, then the result register; the result is on m_axis
// once the result register loads it. Throughput: one byte per cycle while
// m_axis_tready stays high; the byte-wide CRC fold and the escape decode sit in
// the single stage between the registers.
// Reset (synchronous, active low) clears the frame state and loads the
// XMODEM settings (poly 0x1021, init 0x0000).
// When m_axis_tready is low, the result register holds and the input register
// still takes one more byte; s_axis_tready drops once both are full.
module stuffed_frame_receiver_crc16 #(
    parameter int BUF_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Config write port
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfr_pkg::CRC_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
    // Output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] data_byte, [8] frame_restart, [9] overflow, [10] frame_ok,
    // [18:11] payload_length, [23:19] zero
    output logic [sfr_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tuser,  // [0] data_valid
    output logic                            m_axis_tlast   // frame_end
);
    import sfr_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_advance;

    // Stage moves when the input register holds a byte and the result register is free or being drained
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfr_core #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_advance),
        .i_byte      (r_in_byte),
        .o_result    (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.data_valid;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tdata  = {5'b0, r_out.payload_length, r_out.frame_ok, r_out.overflow,
                            r_out.frame_restart, r_out.data_byte};

endmodule
